// ===== rtl/fpw_pkg.sv =====
// ----------------------------------------------------------------------------
// fpw_pkg
// Types and constants shared by the framebuffer pixel writer files.
// ----------------------------------------------------------------------------
package fpw_pkg;

    // Coordinates are taken modulo this limit before use
    localparam int COORD_LIMIT = 4096;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_BASE   = 2'd2;

    // Pixel formats
    localparam logic [3:0] FMT_MONO      = 4'd0;
    localparam logic [3:0] FMT_RGB332    = 4'd1;
    localparam logic [3:0] FMT_RGB565    = 4'd2;
    localparam logic [3:0] FMT_RGB565SW  = 4'd3;
    localparam logic [3:0] FMT_BGR565    = 4'd4;
    localparam logic [3:0] FMT_RGB888    = 4'd5;
    localparam logic [3:0] FMT_BGR888    = 4'd6;
    localparam logic [3:0] FMT_XRGB8888  = 4'd7;
    localparam logic [3:0] FMT_XBGR8888  = 4'd8;
    localparam logic [3:0] FMT_ARGB8888  = 4'd9;
    localparam logic [3:0] FMT_ABGR8888  = 4'd10;
    localparam logic [3:0] FMT_RGBA8888  = 4'd11;
    localparam logic [3:0] FMT_BGRA8888  = 4'd12;

    // Mono colour codes
    localparam logic [31:0] MONO_BLACK  = 32'd0;
    localparam logic [31:0] MONO_WHITE  = 32'd1;
    localparam logic [31:0] MONO_INVERT = 32'd2;

    // Write operations
    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_TOGGLE = 2'd3;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] colour;
    } t_pixel;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] byte_address;
        logic [1:0]  write_op;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } t_wr_req;

endpackage

// ===== rtl/fpw_stream_if.sv =====
// ----------------------------------------------------------------------------
// fpw_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface fpw_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/framebuffer_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer
// Turns one pixel (x, y, colour) into one framebuffer write request.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, stalled only by o_wr.ready.
// Pipeline: input register, product register, result register; the
//   y * line_width multiply and the base + pix * bpp add each own one stage.
// Reset: synchronous, active low; clears pipeline valids and the registers
//   (format mono, line_width 1, frame_base 0).
module framebuffer_pixel_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fpw_stream_if.sink          i_pix,
    fpw_stream_if.source        o_wr,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fpw_pkg::*;

    // ---------------- configuration registers ----------------
    logic [3:0]  r_format;
    logic [12:0] r_line_width;
    logic [31:0] r_frame_base;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= FMT_MONO;
            r_line_width <= 13'd1;
            r_frame_base <= 32'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PIXEL_FORMAT: r_format     <= pwdata[3:0];
                REG_LINE_WIDTH:   r_line_width <= pwdata[12:0];
                REG_FRAME_BASE:   r_frame_base <= pwdata;
                default: ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PIXEL_FORMAT: prdata = {28'd0, r_format};
            REG_LINE_WIDTH:   prdata = {19'd0, r_line_width};
            REG_FRAME_BASE:   prdata = r_frame_base;
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // Each stage advances when it is empty or the next one takes its item.
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_ready, s2_ready, s1_ready;

    assign out_ready   = !r_out_valid || o_wr.ready;
    assign s2_ready    = !r_s2_valid || out_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;
    assign o_wr.valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready)  r_s1_valid  <= i_pix.valid;
            if (s2_ready)  r_s2_valid  <= r_s1_valid;
            if (out_ready) r_out_valid <= r_s2_valid;
        end
    end

    // ---------------- stage 1: input register ----------------
    t_pixel r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) r_s1_pix <= i_pix.payload;
    end

    // ---------------- stage 1 logic: pixel index and lanes ----------------
    logic [11:0] s1_x, s1_y, s1_ysel;
    logic [7:0]  s1_a, s1_r, s1_g, s1_b;
    logic [24:0] s1_prod;
    logic [25:0] n_pix;
    logic        n_en;
    logic [1:0]  n_op;
    logic [2:0]  n_cnt;
    logic [31:0] n_data;

    assign s1_x = 12'(r_s1_pix.pos_x % COORD_LIMIT);
    assign s1_y = 12'(r_s1_pix.pos_y % COORD_LIMIT);
    assign s1_a = r_s1_pix.colour[31:24];
    assign s1_r = r_s1_pix.colour[23:16];
    assign s1_g = r_s1_pix.colour[15:8];
    assign s1_b = r_s1_pix.colour[7:0];

    // Mono packs 8 rows into one byte: the row index is the page number.
    assign s1_ysel = (r_format == FMT_MONO) ? {3'd0, s1_y[11:3]} : s1_y;
    assign s1_prod = {13'd0, s1_ysel} * {12'd0, r_line_width};
    assign n_pix   = {1'b0, s1_prod} + {14'd0, s1_x};

    always_comb begin
        n_en   = 1'b1;
        n_op   = OP_STORE;
        n_cnt  = 3'd4;
        n_data = 32'd0;
        case (r_format)
            FMT_MONO: begin
                n_cnt  = 3'd1;
                n_data = 32'd1 << s1_y[2:0];
                if (r_s1_pix.colour == MONO_BLACK)       n_op = OP_CLEAR;
                else if (r_s1_pix.colour == MONO_WHITE)  n_op = OP_SET;
                else if (r_s1_pix.colour == MONO_INVERT) n_op = OP_TOGGLE;
                else                                     n_en = 1'b0;
            end
            FMT_RGB332: begin
                n_cnt  = 3'd1;
                n_data = {24'd0, s1_r[7:5], s1_g[7:5], s1_b[7:6]};
            end
            FMT_RGB565: begin
                n_cnt  = 3'd2;
                n_data = {16'd0, r_s1_pix.colour[15:0]};
            end
            FMT_RGB565SW: begin
                n_cnt  = 3'd2;
                n_data = {16'd0, r_s1_pix.colour[7:0], r_s1_pix.colour[15:8]};
            end
            FMT_BGR565: begin
                n_cnt  = 3'd2;
                n_data = {16'd0, s1_b[7:3], s1_g[7:2], s1_r[7:3]};
            end
            FMT_RGB888: begin
                n_cnt  = 3'd3;
                n_data = {8'd0, s1_b, s1_g, s1_r};
            end
            FMT_BGR888: begin
                n_cnt  = 3'd3;
                n_data = {8'd0, s1_r, s1_g, s1_b};
            end
            FMT_XRGB8888: n_data = {8'hFF, r_s1_pix.colour[23:0]};
            FMT_XBGR8888: n_data = {s1_r, s1_g, s1_b, 8'hFF};
            FMT_ARGB8888: n_data = r_s1_pix.colour;
            FMT_ABGR8888: n_data = {s1_r, s1_g, s1_b, s1_a};
            FMT_RGBA8888: n_data = {s1_a, s1_b, s1_g, s1_r};
            FMT_BGRA8888: n_data = {s1_a, s1_r, s1_g, s1_b};
            default:      n_en   = 1'b0;  // unused format codes
        endcase
    end

    // ---------------- stage 2: product register ----------------
    logic [25:0] r_s2_pix;
    logic        r_s2_en;
    logic [1:0]  r_s2_op;
    logic [2:0]  r_s2_cnt;
    logic [31:0] r_s2_data;

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_pix  <= n_pix;
            r_s2_en   <= n_en;
            r_s2_op   <= n_op;
            r_s2_cnt  <= n_cnt;
            r_s2_data <= n_data;
        end
    end

    // Byte offset = pixel index * bytes per pixel (mono: one byte per column)
    logic [27:0] s2_offset;
    t_wr_req     n_req;

    always_comb begin
        case (r_s2_cnt)
            3'd2:    s2_offset = {1'b0, r_s2_pix, 1'b0};
            3'd3:    s2_offset = {2'd0, r_s2_pix} + {1'b0, r_s2_pix, 1'b0};
            3'd4:    s2_offset = {r_s2_pix, 2'd0};
            default: s2_offset = {2'd0, r_s2_pix};
        endcase
    end

    always_comb begin
        n_req = '0;
        if (r_s2_en) begin
            n_req.write_enable = 1'b1;
            n_req.byte_address = r_frame_base + {4'd0, s2_offset};
            n_req.write_op     = r_s2_op;
            n_req.byte_count   = r_s2_cnt;
            n_req.write_data   = r_s2_data;
        end
    end

    // ---------------- result register ----------------
    t_wr_req r_out;

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s2_valid) r_out <= n_req;
    end

    assign o_wr.payload = r_out;

endmodule

// ===== rtl/fpw_checker.sv =====
// ----------------------------------------------------------------------------
// fpw_checker
// Port-level checks on the write request channel of the pixel writer.
// ----------------------------------------------------------------------------
module fpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_wr_valid,
    input logic        i_wr_ready,
    input logic        i_wr_en,
    input logic [31:0] i_wr_addr,
    input logic [1:0]  i_wr_op,
    input logic [2:0]  i_wr_cnt,
    input logic [31:0] i_wr_data
);
    import fpw_pkg::*;

    // A dropped write carries an all-zero request
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && !i_wr_en) |->
            (i_wr_addr == 32'd0 && i_wr_op == OP_STORE &&
             i_wr_cnt == 3'd0 && i_wr_data == 32'd0))
        else $error("dropped write has nonzero fields");

    // Issued writes cover one to four bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && i_wr_en) |-> (i_wr_cnt != 3'd0 && i_wr_cnt <= 3'd4))
        else $error("byte count out of range");

    // Masked operations are mono single-byte writes with a one-hot mask
    a_mask_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && i_wr_en && i_wr_op != OP_STORE) |->
            (i_wr_cnt == 3'd1 && $onehot(i_wr_data)))
        else $error("masked op with bad count or mask");

    // Nothing is offered in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_wr_valid)
        else $error("request valid right after reset");

    // A stalled request holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && !i_wr_ready) |=>
            (i_wr_valid && $stable(i_wr_addr) && $stable(i_wr_data)))
        else $error("stalled request changed");

endmodule

bind framebuffer_pixel_writer fpw_checker u_fpw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_wr_valid (o_wr.valid),
    .i_wr_ready (o_wr.ready),
    .i_wr_en    (o_wr.payload.write_enable),
    .i_wr_addr  (o_wr.payload.byte_address),
    .i_wr_op    (o_wr.payload.write_op),
    .i_wr_cnt   (o_wr.payload.byte_count),
    .i_wr_data  (o_wr.payload.write_data)
);

// ===== tb/fpw_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// fpw_scoreboard_pkg
// Write-request predictor and in-order result checker for the pixel writer.
// ----------------------------------------------------------------------------
package fpw_scoreboard_pkg;

    import fpw_pkg::*;

    class wr_req_scoreboard;

        logic [3:0]  pixel_format;
        logic [12:0] line_width;
        logic [31:0] frame_base;
        t_wr_req     expected_q[$];
        int          errors;

        function new();
            pixel_format = FMT_MONO;
            line_width   = 13'd1;
            frame_base   = 32'd0;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_PIXEL_FORMAT: pixel_format = value[3:0];
                REG_LINE_WIDTH:   line_width   = value[12:0];
                REG_FRAME_BASE:   frame_base   = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_PIXEL_FORMAT: return {28'd0, pixel_format};
                REG_LINE_WIDTH:   return {19'd0, line_width};
                REG_FRAME_BASE:   return frame_base;
                default:          return 32'd0;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Memory request for one pixel under the current register settings
        function t_wr_req pack_pixel(t_pixel p);
            logic [31:0] xw;
            logic [31:0] yw;
            logic [31:0] c;
            logic [31:0] pix;
            logic [7:0]  a;
            logic [7:0]  r;
            logic [7:0]  g;
            logic [7:0]  bl;
            logic [31:0] bpp;
            t_wr_req     q;
            xw  = 32'(p.pos_x) % COORD_LIMIT;
            yw  = 32'(p.pos_y) % COORD_LIMIT;
            c   = p.colour;
            a   = c[31:24];
            r   = c[23:16];
            g   = c[15:8];
            bl  = c[7:0];
            pix = xw + yw * 32'(line_width);
            bpp = 32'd0;
            q   = '0;
            q.write_enable = 1'b1;
            q.write_op     = OP_STORE;
            case (pixel_format)
                FMT_MONO: begin
                    q.byte_address = frame_base + (yw >> 3) * 32'(line_width) + xw;
                    q.byte_count   = 3'd1;
                    q.write_data   = 32'd1 << yw[2:0];
                    case (c)
                        MONO_BLACK:  q.write_op = OP_CLEAR;
                        MONO_WHITE:  q.write_op = OP_SET;
                        MONO_INVERT: q.write_op = OP_TOGGLE;
                        default:     q.write_enable = 1'b0;
                    endcase
                end
                FMT_RGB332: begin
                    bpp = 32'd1;
                    q.write_data = {24'd0, (r & 8'hE0) | ((g >> 3) & 8'h1C) | (bl >> 6)};
                end
                FMT_RGB565: begin
                    bpp = 32'd2;
                    q.write_data = {16'd0, c[15:0]};
                end
                FMT_RGB565SW: begin
                    bpp = 32'd2;
                    q.write_data = {16'd0, c[7:0], c[15:8]};
                end
                FMT_BGR565: begin
                    bpp = 32'd2;
                    q.write_data = {16'd0, bl[7:3], g[7:2], r[7:3]};
                end
                FMT_RGB888: begin
                    bpp = 32'd3;
                    q.write_data = {8'd0, bl, g, r};
                end
                FMT_BGR888: begin
                    bpp = 32'd3;
                    q.write_data = {8'd0, r, g, bl};
                end
                FMT_XRGB8888: begin
                    bpp = 32'd4;
                    q.write_data = {8'hFF, c[23:0]};
                end
                FMT_XBGR8888: begin
                    bpp = 32'd4;
                    q.write_data = {r, g, bl, 8'hFF};
                end
                FMT_ARGB8888: begin
                    bpp = 32'd4;
                    q.write_data = c;
                end
                FMT_ABGR8888: begin
                    bpp = 32'd4;
                    q.write_data = {r, g, bl, a};
                end
                FMT_RGBA8888: begin
                    bpp = 32'd4;
                    q.write_data = {a, bl, g, r};
                end
                FMT_BGRA8888: begin
                    bpp = 32'd4;
                    q.write_data = {a, r, g, bl};
                end
                default: q.write_enable = 1'b0;
            endcase
            if (bpp != 32'd0) begin
                q.byte_count   = bpp[2:0];
                q.byte_address = frame_base + pix * bpp;
            end
            // no write: all fields zero
            if (!q.write_enable)
                q = '0;
            return q;
        endfunction

        function void note_pixel(t_pixel p);
            expected_q.push_back(pack_pixel(p));
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_wr_req got);
            t_wr_req exp_req;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected write request %h", got));
                return;
            end
            exp_req = expected_q.pop_front();
            if (got.write_enable !== exp_req.write_enable)
                report($sformatf("write_enable got %b exp %b",
                                 got.write_enable, exp_req.write_enable));
            if (got.byte_address !== exp_req.byte_address)
                report($sformatf("byte_address got %h exp %h",
                                 got.byte_address, exp_req.byte_address));
            if (got.write_op !== exp_req.write_op)
                report($sformatf("write_op got %0d exp %0d",
                                 got.write_op, exp_req.write_op));
            if (got.byte_count !== exp_req.byte_count)
                report($sformatf("byte_count got %0d exp %0d",
                                 got.byte_count, exp_req.byte_count));
            if (got.write_data !== exp_req.write_data)
                report($sformatf("write_data got %h exp %h",
                                 got.write_data, exp_req.write_data));
        endtask

    endclass

endpackage

// ===== tb/framebuffer_pixel_writer_tb.sv =====
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_tb
// Drives pixels and register settings into the pixel writer, predicts each
// write request and checks the requests in order, under random back-pressure.
// ----------------------------------------------------------------------------
module framebuffer_pixel_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpw_pkg::*;
    import fpw_scoreboard_pkg::*;

    localparam int BLOCK_ITEMS  = 25;   // random items between setting changes
    localparam int BLOCKS       = 10;   // per idling phase
    localparam int PIPE_DRAIN   = 4;    // pipeline is 3 deep
    localparam int DRAIN_LIMIT  = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // idle odds in percent, per side
    int send_idle_pct;
    int recv_idle_pct;

    wr_req_scoreboard sb;

    fpw_stream_if #(.t_payload(t_pixel))  pix_if ();
    fpw_stream_if #(.t_payload(t_wr_req)) wr_if ();

    framebuffer_pixel_writer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs
    initial begin
        #5_000_000;
        $display("framebuffer_pixel_writer_tb: done, errors");
        $finish;
    end

    // Receiver: ready toggles at the falling edge with the current odds
    initial begin
        wr_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            wr_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output first, then input: a request can never share an edge with its
    // own pixel, so the order only matters for an empty queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (wr_if.valid && wr_if.ready)
                sb.check_result(wr_if.payload);
            if (pix_if.valid && pix_if.ready)
                sb.note_pixel(pix_if.payload);
        end
    end

    // One APB transfer: setup, then access until pready
    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read a register back and compare with the shadow copy
    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, 32'd0, rd);
        if (rd !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads %h exp %h",
                                idx, rd, sb.reg_value(idx)));
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, value, unused);
        sb.write_reg(idx, value);
        check_reg(idx);
    endtask

    // Block idle: every request back, plus a few cycles of margin
    task automatic wait_drained();
        int n;
        n = 0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [3:0] fmt, input logic [12:0] width,
                                 input logic [31:0] base);
        wait_drained();
        set_reg(REG_PIXEL_FORMAT, {28'd0, fmt});
        set_reg(REG_LINE_WIDTH, {19'd0, width});
        set_reg(REG_FRAME_BASE, base);
    endtask

    // Present one pixel, with random idle cycles ahead of it; valid stays
    // high into the next item when no gap is rolled.
    task automatic push_pixel(input t_pixel p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid   = 1'b1;
        pix_if.payload = p;
        do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
    endtask

    task automatic stop_pixels();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
    endtask

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    // Mono pixels mostly carry a valid code; other formats take any colour
    function automatic t_pixel rand_pixel(input logic [3:0] fmt);
        t_pixel p;
        p.pos_x = rand_coord();
        p.pos_y = rand_coord();
        if (fmt == FMT_MONO && $urandom_range(9) != 0)
            p.colour = 32'($urandom_range(2));
        else
            p.colour = $urandom;
        return p;
    endfunction

    initial begin
        logic [3:0]  fmt;
        logic [12:0] width;
        logic [31:0] base;
        t_pixel      p;

        sb = new();
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pix_if.valid   = 1'b0;
        pix_if.payload = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the registers
        check_reg(REG_PIXEL_FORMAT);
        check_reg(REG_LINE_WIDTH);
        check_reg(REG_FRAME_BASE);

        // ---- directed ----
        // mono at the coordinate corners, base near the top so addresses wrap
        apply_setting(FMT_MONO, 13'd4096, 32'hFFFF_FFF0);
        push_pixel('{pos_x: 12'd0,    pos_y: 12'd0,    colour: MONO_BLACK});
        push_pixel('{pos_x: 12'hFFF,  pos_y: 12'hFFF,  colour: MONO_WHITE});
        push_pixel('{pos_x: 12'd7,    pos_y: 12'd9,    colour: MONO_INVERT});
        // codes other than black/white/invert write nothing
        push_pixel('{pos_x: 12'd1,    pos_y: 12'd2,    colour: 32'd3});
        push_pixel('{pos_x: 12'hFFF,  pos_y: 12'd0,    colour: 32'hFFFF_FFFF});
        stop_pixels();
        // zero line width is used as given
        apply_setting(FMT_MONO, 13'd0, 32'd0);
        push_pixel('{pos_x: 12'd5,    pos_y: 12'hFFF,  colour: MONO_WHITE});
        stop_pixels();
        // each packed format once, then the unused codes; width past its
        // range and distinct bytes so lane swaps show
        for (int f = 1; f < 16; f++) begin
            apply_setting(4'(f), 13'h1FFF, $urandom);
            push_pixel('{pos_x: 12'hFFF, pos_y: 12'hFFF, colour: 32'h8142_C3A5});
            stop_pixels();
        end

        // ---- random, three idling phases ----
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 65;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                fmt = ($urandom_range(19) < 17) ? 4'($urandom_range(12))
                                                : 4'($urandom_range(15, 13));
                case ($urandom_range(9))
                    0:       width = 13'd0;
                    1:       width = 13'd1;
                    2:       width = 13'd4096;
                    3:       width = 13'h1FFF;
                    default: width = 13'($urandom_range(4096, 1));
                endcase
                case ($urandom_range(5))
                    0:       base = 32'd0;
                    1:       base = 32'hFFFF_FFFF;
                    default: base = $urandom;
                endcase
                apply_setting(fmt, width, base);
                for (int k = 0; k < BLOCK_ITEMS; k++) begin
                    p = rand_pixel(fmt);
                    push_pixel(p);
                end
                stop_pixels();
            end
        end

        // ---- drain and verdict ----
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d write requests never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("framebuffer_pixel_writer_tb: done, clean");
        end else begin
            $display("framebuffer_pixel_writer_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpw_pkg.sv
rtl/fpw_stream_if.sv
rtl/framebuffer_pixel_writer.sv
rtl/fpw_checker.sv
tb/fpw_scoreboard_pkg.sv
tb/framebuffer_pixel_writer_tb.sv
